/* rtl/core/tbac_pkg.sv */
// Shared types, constants and codes for the texture binding alpha classifier.
`timescale 1ns / 1ps

package tbac_pkg;

  localparam int unsigned TableSize     = 2048;
  localparam int unsigned IdxW          = $clog2(TableSize);
  localparam int unsigned TidW          = 12;
  localparam int unsigned SlotCntW      = 12;
  localparam int unsigned SlotW         = 11;
  localparam int unsigned MaxPrimitives = 65536;
  localparam int unsigned PrimCntW      = $clog2(MaxPrimitives);
  localparam int unsigned PrimW         = 16;
  localparam int unsigned AlphaW        = 8;
  localparam logic [AlphaW-1:0] AlphaFull = 8'd255;

  typedef enum logic [1:0] {
    CMD_REG    = 2'd0,
    CMD_VERTEX = 2'd1,
    CMD_EMPTY  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_TEX_ID  = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_MISSING = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CLS_VARIABLE    = 2'd0,
    CLS_OPAQUE      = 2'd1,
    CLS_TRANSPARENT = 2'd2
  } alpha_class_e;

  typedef enum logic [1:0] {
    OP_REG,
    OP_EMPTY,
    OP_PRIM
  } op_e;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_FETCH,
    BK_LOOK
  } bk_state_e;

  typedef struct packed {
    logic [1:0]        command;
    logic [TidW-1:0]   tex_ref;
    logic              has_texture;
    logic              skip_primitive;
    logic              selector_flag;
    logic [AlphaW-1:0] vertex_alpha;
    logic              last_vertex;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [PrimW-1:0]  primitive_index;
    logic              texture_bound;
    logic [SlotW-1:0]  texture_slot;
    logic              selector_flag_out;
    logic [1:0]        alpha_class;
    logic [AlphaW-1:0] alpha_min;
    logic [AlphaW-1:0] alpha_max;
  } out_item_t;

  // Work handed from the front end to the back end.
  typedef struct packed {
    op_e               kind;
    logic [TidW-1:0]   tid;
    logic              has_tex;
    logic              sel;
    logic [PrimW-1:0]  prim;
    logic [SlotW-1:0]  slot;
    logic [AlphaW-1:0] amin;
    logic [AlphaW-1:0] amax;
  } op_t;

  typedef struct packed {
    logic clearing;
    logic error;
  } bk_status_t;

endpackage

/* rtl/core/tbac_front.sv */
// Front end: accepts items, tracks primitive alpha range and counters, queues work.
`timescale 1ns / 1ps

module tbac_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tbac_pkg::in_item_t  in_data_i,
  input  logic                q_full_i,
  input  logic                clearing_i,
  output logic                push_o,
  output tbac_pkg::op_t       push_data_o
);
  import tbac_pkg::*;

  logic [SlotCntW-1:0] slot_q, slot_d;
  logic [PrimCntW-1:0] prim_q, prim_d, prim_next;
  logic [AlphaW-1:0]   min_q, min_d, max_q, max_d;
  logic [AlphaW-1:0]   new_min, new_max;
  logic                accept;

  assign in_stall_o = q_full_i || clearing_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign new_min    = (in_data_i.vertex_alpha < min_q) ? in_data_i.vertex_alpha : min_q;
  assign new_max    = (in_data_i.vertex_alpha > max_q) ? in_data_i.vertex_alpha : max_q;
  assign prim_next  = (prim_q == PrimCntW'(MaxPrimitives - 1)) ? '0 : prim_q + 1'b1;

  always_comb begin
    slot_d                  = slot_q;
    prim_d                  = prim_q;
    min_d                   = min_q;
    max_d                   = max_q;
    push_o                  = 1'b0;
    push_data_o.kind        = OP_REG;
    push_data_o.tid         = in_data_i.tex_ref;
    push_data_o.has_tex     = in_data_i.has_texture;
    push_data_o.sel         = in_data_i.selector_flag;
    push_data_o.prim        = PrimW'(prim_q);
    push_data_o.slot        = slot_q[SlotW-1:0];
    push_data_o.amin        = new_min;
    push_data_o.amax        = new_max;
    if (accept) begin
      case (cmd_e'(in_data_i.command))
        CMD_REG: begin
          push_o = 1'b1;
          slot_d = slot_q + 1'b1;
        end
        CMD_EMPTY: begin
          push_data_o.kind = OP_EMPTY;
          push_o           = !in_data_i.skip_primitive;
          prim_d           = prim_next;
          min_d            = AlphaFull;
          max_d            = '0;
        end
        CMD_VERTEX: begin
          if (in_data_i.last_vertex) begin
            push_data_o.kind = OP_PRIM;
            push_o           = !in_data_i.skip_primitive;
            prim_d           = prim_next;
            min_d            = AlphaFull;
            max_d            = '0;
          end else begin
            min_d = new_min;
            max_d = new_max;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      prim_q <= '0;
      min_q  <= AlphaFull;
      max_q  <= '0;
    end else begin
      slot_q <= slot_d;
      prim_q <= prim_d;
      min_q  <= min_d;
      max_q  <= max_d;
    end
  end

endmodule

/* rtl/core/tbac_queue.sv */
// Two-entry work queue between the front end and the back end.
`timescale 1ns / 1ps

module tbac_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tbac_pkg::op_t  push_data_i,
  input  logic           pop_i,
  output tbac_pkg::op_t  head_o,
  output logic           empty_o,
  output logic           full_o
);
  import tbac_pkg::*;

  op_t        slots_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign empty_o = (count_q == 2'd0);
  assign full_o  = (count_q == 2'd2);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: ;
      endcase
    end
  end

endmodule

/* rtl/core/tbac_back.sv */
// Back end: texture directory, lookups, error latch and the result register.
`timescale 1ns / 1ps

module tbac_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   q_empty_i,
  input  tbac_pkg::op_t          q_head_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output tbac_pkg::out_item_t    out_data_o,
  output tbac_pkg::bk_status_t   status_o
);
  import tbac_pkg::*;

  logic             vld_mem [TableSize];
  logic [SlotW-1:0] idx_mem [TableSize];

  bk_state_e        state_q, state_d;
  logic [IdxW-1:0]  clr_q, clr_d;
  logic             err_q, err_d;
  op_t              op_q;
  logic             vld_rd_q;
  logic [SlotW-1:0] idx_rd_q;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q, out_d;

  logic             vld_we, vld_wval, idx_we;
  logic [IdxW-1:0]  wr_addr;
  logic             oor, out_free, need_out;
  out_item_t        result;
  alpha_class_e     cls;

  assign oor      = (32'(op_q.tid) >= TableSize);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    if (op_q.amin == AlphaFull && op_q.amax == AlphaFull) begin
      cls = CLS_OPAQUE;
    end else if (op_q.amin == '0 && op_q.amax == '0) begin
      cls = CLS_TRANSPARENT;
    end else begin
      cls = CLS_VARIABLE;
    end
  end

  // Decide the outcome of the op held in op_q using the registered directory read.
  always_comb begin
    result   = '0;
    need_out = 1'b0;
    case (op_q.kind)
      OP_REG: begin
        if (oor || vld_rd_q) begin
          result.status = ST_TEX_ID;
          need_out      = 1'b1;
        end
      end
      OP_EMPTY: begin
        result.status          = ST_EMPTY;
        result.primitive_index = op_q.prim;
        need_out               = 1'b1;
      end
      OP_PRIM: begin
        need_out               = 1'b1;
        result.primitive_index = op_q.prim;
        if (op_q.has_tex && (oor || !vld_rd_q)) begin
          result.status = ST_MISSING;
        end else begin
          result.status            = ST_OK;
          result.texture_bound     = op_q.has_tex;
          result.texture_slot      = op_q.has_tex ? idx_rd_q : '0;
          result.selector_flag_out = op_q.sel;
          result.alpha_class       = cls;
          result.alpha_min         = op_q.amin;
          result.alpha_max         = op_q.amax;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    err_d       = err_q;
    pop_o       = 1'b0;
    vld_we      = 1'b0;
    vld_wval    = 1'b0;
    idx_we      = 1'b0;
    wr_addr     = op_q.tid[IdxW-1:0];
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    case (state_q)
      BK_CLEAR: begin
        vld_we  = 1'b1;
        wr_addr = clr_q;
        clr_d   = clr_q + 1'b1;
        if (clr_q == IdxW'(TableSize - 1)) begin
          state_d = BK_FETCH;
        end
      end
      BK_FETCH: begin
        if (!q_empty_i) begin
          pop_o   = 1'b1;
          state_d = BK_LOOK;
        end
      end
      BK_LOOK: begin
        if (err_q) begin
          // Silent after an error: drop the op.
          state_d = BK_FETCH;
        end else if (!need_out || out_free) begin
          state_d = BK_FETCH;
          if (op_q.kind == OP_REG && !need_out) begin
            vld_we   = 1'b1;
            vld_wval = 1'b1;
            idx_we   = 1'b1;
          end
          if (need_out) begin
            out_valid_d = 1'b1;
            out_d       = result;
            err_d       = (result.status != ST_OK);
          end
        end
      end
      default: state_d = BK_FETCH;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (vld_we) begin
      vld_mem[wr_addr] <= vld_wval;
    end
    if (idx_we) begin
      idx_mem[wr_addr] <= op_q.slot;
    end
    if (pop_o) begin
      vld_rd_q <= vld_mem[q_head_i.tid[IdxW-1:0]];
      idx_rd_q <= idx_mem[q_head_i.tid[IdxW-1:0]];
      op_q     <= q_head_i;
    end
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_CLEAR;
      clr_q       <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_q;
  assign status_o.clearing = (state_q == BK_CLEAR);
  assign status_o.error    = err_q;

endmodule

/* rtl/core/texture_binding_alpha_classifier.sv */
// Top level of the texture binding alpha classifier.
`timescale 1ns / 1ps

// Texture registrations fill a 2048-entry directory of load indexes (a bad
// one yields an error result); vertex beats accumulate each primitive's alpha
// range, and the beat that ends a primitive yields one binding result unless
// skipped (or an error result, after which the block stays silent until
// reset). After reset the block clears the directory valid memory, one entry a
// cycle, with in_stall_o high. After that the front end takes one beat a cycle
// while the queue is not full; vertex beats that do not end a primitive stay
// in the front end. Registrations and unskipped primitive-ending beats enter a
// two-entry queue, and the back end handles each with a directory read, then
// a decision and directory write, fetching the next only after that decision.
module texture_binding_alpha_classifier (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  tbac_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output tbac_pkg::out_item_t  out_data_o
);
  import tbac_pkg::*;

  logic       push, pop, q_empty, q_full;
  op_t        push_data, q_head;
  bk_status_t bk_status;

  tbac_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .q_full_i    (q_full),
    .clearing_i  (bk_status.clearing),
    .push_o      (push),
    .push_data_o (push_data)
  );

  tbac_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (q_head),
    .empty_o     (q_empty),
    .full_o      (q_full)
  );

  tbac_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_head_i    (q_head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .status_o    (bk_status)
  );

  // Once the error latch is set, no new result may appear.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_status.error && !out_valid_o |=> !out_valid_o)
    else $error("result produced after sticky error");

  // An error result that is taken is the last result until reset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && out_data_o.status != ST_OK |=> !out_valid_o)
    else $error("result follows an error result");

  // No result can exist while the directory is still being cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_status.clearing |-> !out_valid_o)
    else $error("result during directory clearing");

  // Error results carry no binding or alpha information.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_OK |->
      !out_data_o.texture_bound && out_data_o.alpha_min == '0 &&
      out_data_o.alpha_max == '0)
    else $error("error result carries payload");

endmodule

/* tb/sv/tbac_binding_checker.sv */
// Channel monitor, binding predictor and result comparison for the alpha classifier.
`timescale 1ns / 1ps

module tbac_binding_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  tbac_pkg::in_item_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  tbac_pkg::out_item_t out_data_i,
  output int                  fail_count_o,
  output int                  pending_o,
  output int                  bindings_seen_o,
  output int                  errors_seen_o
);
  import tbac_pkg::*;

  // Shadow of the texture directory and of the primitive accumulator.
  logic                dir_known [TableSize];
  logic [SlotW-1:0]    dir_slot  [TableSize];
  logic [SlotCntW-1:0] load_count;
  logic [PrimW-1:0]    prim_count;
  logic [AlphaW-1:0]   low_alpha;
  logic [AlphaW-1:0]   high_alpha;
  logic                silenced;
  out_item_t           bindings_due [$];

  task automatic close_primitive(output logic [PrimW-1:0] prim);
    prim       = prim_count;
    prim_count = prim_count + 1'b1;
    low_alpha  = AlphaFull;
    high_alpha = '0;
  endtask

  // Updates the shadow state for one input beat and queues the binding it yields.
  task automatic classify_beat(input in_item_t b);
    out_item_t         r;
    logic [PrimW-1:0]  prim;
    logic [AlphaW-1:0] amin;
    logic [AlphaW-1:0] amax;
    logic              tid_ok;
    logic [IdxW-1:0]   idx;
    r      = '0;
    tid_ok = (b.tex_ref < TableSize);
    idx    = b.tex_ref[IdxW-1:0];
    if (silenced) return;
    case (b.command)
      CMD_REG: begin
        if (!tid_ok || dir_known[idx]) begin
          r.status     = ST_TEX_ID;
          silenced     = 1'b1;
          bindings_due = {bindings_due, r};
        end else begin
          dir_slot[idx]  = load_count[SlotW-1:0];
          dir_known[idx] = 1'b1;
          load_count     = load_count + 1'b1;
        end
      end
      CMD_EMPTY: begin
        close_primitive(prim);
        if (!b.skip_primitive) begin
          r.status          = ST_EMPTY;
          r.primitive_index = prim;
          silenced          = 1'b1;
          bindings_due      = {bindings_due, r};
        end
      end
      CMD_VERTEX: begin
        if (b.vertex_alpha < low_alpha) low_alpha = b.vertex_alpha;
        if (b.vertex_alpha > high_alpha) high_alpha = b.vertex_alpha;
        if (b.last_vertex) begin
          amin = low_alpha;
          amax = high_alpha;
          close_primitive(prim);
          if (!b.skip_primitive) begin
            r.primitive_index = prim;
            if (b.has_texture && (!tid_ok || !dir_known[idx])) begin
              r.status = ST_MISSING;
              silenced = 1'b1;
            end else begin
              r.status            = ST_OK;
              r.texture_bound     = b.has_texture;
              r.texture_slot      = b.has_texture ? dir_slot[idx] : '0;
              r.selector_flag_out = b.selector_flag;
              r.alpha_min         = amin;
              r.alpha_max         = amax;
              if (amin == AlphaFull && amax == AlphaFull) begin
                r.alpha_class = CLS_OPAQUE;
              end else if (amin == '0 && amax == '0) begin
                r.alpha_class = CLS_TRANSPARENT;
              end else begin
                r.alpha_class = CLS_VARIABLE;
              end
            end
            bindings_due = {bindings_due, r};
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      for (int i = 0; i < TableSize; i++) dir_known[i] = 1'b0;
      load_count = '0;
      prim_count = '0;
      low_alpha  = AlphaFull;
      high_alpha = '0;
      silenced   = 1'b0;
      bindings_due.delete();
      pending_o <= 0;
    end else begin
      // Input first, so that a binding queued and delivered on one edge stays in order.
      if (in_valid_i && !in_stall_i) classify_beat(in_data_i);
      if (out_valid_i && !out_stall_i) begin
        if (bindings_due.size() == 0) begin
          $error("unexpected result beat: status %0d, primitive %0d",
                 out_data_i.status, out_data_i.primitive_index);
          fail_count_o++;
        end else begin
          want = bindings_due.pop_front();
          check_field("status", want.status, out_data_i.status);
          check_field("primitive_index", want.primitive_index, out_data_i.primitive_index);
          check_field("texture_bound", want.texture_bound, out_data_i.texture_bound);
          check_field("texture_slot", want.texture_slot, out_data_i.texture_slot);
          check_field("selector_flag_out", want.selector_flag_out,
                      out_data_i.selector_flag_out);
          check_field("alpha_class", want.alpha_class, out_data_i.alpha_class);
          check_field("alpha_min", want.alpha_min, out_data_i.alpha_min);
          check_field("alpha_max", want.alpha_max, out_data_i.alpha_max);
          if (want.status == ST_OK) begin
            bindings_seen_o++;
          end else begin
            errors_seen_o++;
          end
        end
      end
      pending_o <= bindings_due.size();
    end
  end

endmodule

/* tb/sv/texture_binding_alpha_classifier_test.sv */
// Stimulus, flow control and final verdict for the texture binding alpha classifier.
`timescale 1ns / 1ps

module texture_binding_alpha_classifier_test;
  import tbac_pkg::*;

  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned RandomBeats = 1500;
  localparam int unsigned TailBeats   = 200;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned TidTop      = (1 << TidW) - 1;
  localparam logic [1:0]  CmdUnused   = 2'd3;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  int fail_count;
  int pending;
  int bindings_seen;
  int errors_seen;

  bit          tex_taken [TableSize];
  int unsigned tex_list [$];
  int unsigned beats_sent  = 0;
  int unsigned prims_sent  = 0;
  int unsigned cycle_count = 0;
  bit          tx_calm     = 1'b0;
  bit          rx_calm     = 1'b0;
  bit          hold_req    = 1'b0;
  string       closing_error;

  texture_binding_alpha_classifier i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  tbac_binding_checker i_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .in_data_i       (in_data),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .out_data_i      (out_data),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .bindings_seen_o (bindings_seen),
    .errors_seen_o   (errors_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic in_item_t rand_beat();
    logic [31:0] raw;
    raw = $urandom();
    return raw[$bits(in_item_t)-1:0];
  endfunction

  function automatic int unsigned fresh_tid();
    int unsigned t;
    do t = $urandom_range(0, TableSize - 1); while (tex_taken[t]);
    return t;
  endfunction

  function automatic logic [AlphaW-1:0] pick_alpha(input int unsigned mode);
    case (mode)
      0: return AlphaFull;
      1: return '0;
      2: return $urandom_range(0, 1) ? AlphaFull : '0;
      3: return $urandom_range(0, 1) ? AlphaW'(255 - $urandom_range(0, 2))
                                     : AlphaW'($urandom_range(0, 2));
      default: return AlphaW'($urandom());
    endcase
  endfunction

  // Offers one beat, with an occasional idle burst in front, and holds it until taken.
  task automatic send(input in_item_t b);
    if (!tx_calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (b.command != CmdUnused) beats_sent++;
    if (b.command == CMD_EMPTY || (b.command == CMD_VERTEX && b.last_vertex)) prims_sent++;
  endtask

  task automatic send_item(input logic [1:0] cmd, input int unsigned tid, input bit has_tex,
                           input bit skip, input bit sel, input int unsigned alpha,
                           input bit last);
    in_item_t b;
    b.command        = cmd;
    b.tex_ref        = TidW'(tid);
    b.has_texture    = has_tex;
    b.skip_primitive = skip;
    b.selector_flag  = sel;
    b.vertex_alpha   = AlphaW'(alpha);
    b.last_vertex    = last;
    send(b);
  endtask

  task automatic send_reg(input int unsigned tid);
    tex_taken[tid] = 1'b1;
    tex_list       = {tex_list, tid};
    send_item(CMD_REG, tid, $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
              $urandom_range(0, 255), $urandom_range(0, 1));
  endtask

  // Beats that yield no result: unused commands, skipped empties, registrations.
  task automatic send_noise();
    in_item_t b;
    b = rand_beat();
    case ($urandom_range(0, 2))
      0: b.command = CmdUnused;
      1: begin
        b.command        = CMD_EMPTY;
        b.skip_primitive = 1'b1;
      end
      default: begin
        if (tex_list.size() < 1800) send_reg(fresh_tid());
        return;
      end
    endcase
    send(b);
  endtask

  // A whole primitive; fields other than the alpha on the non-final vertices are random
  // since only the final one's count. A rough primitive has noise beats mixed in before vertices.
  task automatic send_prim(input bit skip, input bit rough);
    int unsigned nv;
    int unsigned mode;
    in_item_t    b;
    nv   = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 16) : $urandom_range(1, 4);
    mode = $urandom_range(0, 4);
    for (int unsigned i = 0; i < nv; i++) begin
      if (rough && $urandom_range(0, 2) == 0) send_noise();
      b              = rand_beat();
      b.command      = CMD_VERTEX;
      b.vertex_alpha = pick_alpha(mode);
      b.last_vertex  = (i == nv - 1);
      if (b.last_vertex) begin
        b.skip_primitive = skip;
        if (!skip) begin
          b.has_texture = (tex_list.size() != 0) && ($urandom_range(0, 3) != 0);
          if (b.has_texture) begin
            b.tex_ref = TidW'(tex_list[$urandom_range(0, tex_list.size() - 1)]);
          end
        end
      end
      send(b);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Result side: stall bursts, clean stretches and one long hold-off on request.
  initial begin
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 1'b0;
      end else if (!rx_calm && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("texture_binding_alpha_classifier: mismatch");
    $finish;
  end

  initial begin
    int unsigned base;
    int unsigned pick;
    int unsigned kind;
    bit          pressed;
    bit          paused;
    pressed = 1'b0;
    paused  = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: table edges, each alpha class, skips, unused command, mid-primitive
    // registration and primitives without a texture.
    send_reg(0);
    send_reg(TableSize - 1);
    send_reg(1365);
    send_item(CMD_VERTEX, TableSize - 1, 1, 0, 1, 255, 1);
    send_item(CMD_VERTEX, TidTop, 1, 1, 1, 0, 0);
    send_item(CMD_VERTEX, 0, 1, 0, 0, 0, 1);
    send_item(CMD_VERTEX, 7, 0, 0, 0, 17, 0);
    send_item(CMD_VERTEX, 9, 1, 1, 0, 200, 0);
    send_item(CMD_VERTEX, TidTop, 0, 0, 1, 90, 1);
    send_item(CMD_VERTEX, 0, 0, 0, 0, 255, 0);
    send_item(CMD_VERTEX, 1365, 1, 0, 0, 0, 1);
    send_item(CMD_VERTEX, TidTop, 1, 1, 1, 33, 1);
    send_item(CMD_EMPTY, TidTop, 1, 1, 1, 255, 1);
    send_item(CmdUnused, TidTop, 1, 0, 1, 255, 1);
    send_item(CMD_VERTEX, 0, 0, 0, 0, 128, 0);
    send_reg(1730);
    send_item(CMD_VERTEX, 1730, 1, 0, 1, 127, 1);
    send_item(CMD_VERTEX, 0, 1, 0, 0, 254, 1);
    send_item(CMD_VERTEX, TidTop, 0, 0, 1, 1, 1);
    send_item(CMD_EMPTY, TidTop, 1, 1, 0, 0, 0);
    drain();

    base = beats_sent;
    while (beats_sent < base + RandomBeats) begin
      if (!pressed && beats_sent >= base + 500) begin
        // The result side holds off while primitives keep coming, so the block backs up.
        pressed  = 1'b1;
        hold_req = 1'b1;
        tx_calm  = 1'b1;
        repeat (40) send_prim(1'b0, 1'b0);
        tx_calm  = 1'b0;
      end
      if (!paused && beats_sent >= base + 1000) begin
        paused = 1'b1;
        drain();
      end
      if (beats_sent + TailBeats >= base + RandomBeats) begin
        tx_calm = 1'b1;
        rx_calm = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 14 && tex_list.size() < 1800) begin
        send_reg(fresh_tid());
      end else if (pick < 72) begin
        send_prim($urandom_range(0, 7) == 0, 1'b0);
      end else if (pick < 80) begin
        send_noise();
      end else begin
        send_prim($urandom_range(0, 7) == 0, 1'b1);
      end
    end
    drain();

    // One error ends the useful life of the block; the beats after it must be ignored.
    kind = $urandom_range(0, 4);
    case (kind)
      0: begin
        closing_error = "duplicate texture registration";
        send_item(CMD_REG, tex_list[$urandom_range(0, tex_list.size() - 1)], 0, 0, 0, 0, 0);
      end
      1: begin
        closing_error = "texture ID beyond the table";
        send_item(CMD_REG, $urandom_range(TableSize, TidTop), 1, 1, 1, 255, 1);
      end
      2: begin
        closing_error = "empty primitive";
        send_item(CMD_EMPTY, $urandom_range(0, TidTop), 1, 0, 1, 0, 0);
      end
      3: begin
        closing_error = "unregistered texture";
        send_item(CMD_VERTEX, fresh_tid(), 1, 0, 1, 77, 1);
      end
      default: begin
        closing_error = "referenced ID beyond the table";
        send_item(CMD_VERTEX, $urandom_range(TableSize, TidTop), 1, 0, 0, 200, 1);
      end
    endcase
    repeat (12) send(rand_beat());
    drain();
    repeat (16) @(posedge clk);

    $display("Sent %0d beats over %0d primitives with %0d textures registered.",
             beats_sent, prims_sent, tex_list.size());
    $display("Checked %0d bindings and %0d error results; run closed on %s.",
             bindings_seen, errors_seen, closing_error);
    if (fail_count == 0 && pending == 0) begin
      $display("texture_binding_alpha_classifier: match");
    end else begin
      $display("texture_binding_alpha_classifier: mismatch");
    end
    $finish;
  end

endmodule

/* texture_binding_alpha_classifier.f */
rtl/core/tbac_pkg.sv
rtl/core/tbac_front.sv
rtl/core/tbac_queue.sv
rtl/core/tbac_back.sv
rtl/core/texture_binding_alpha_classifier.sv
tb/sv/tbac_binding_checker.sv
tb/sv/texture_binding_alpha_classifier_test.sv
